[rtl/sv39ptw_pkg.sv]
// Package for the Sv39 translation unit: operation, result and access codes,
// register indexes, TLB geometry and the TLB entry type.
// Depends on nothing; used by sv39_tlb_page_table_walker.
package sv39ptw_pkg;

	// TLB geometry. The index is the low bits of the virtual page number.
	localparam int TLB_ENTRIES = 64;
	localparam int IDX_W       = $clog2(TLB_ENTRIES);

	// Address layout.
	localparam int VA_W     = 64;
	localparam int PG_SHIFT = 12;
	localparam int TAG_W    = VA_W - PG_SHIFT;
	localparam int PPN_W    = 44;
	localparam int VPN_W    = 9;

	// Operation codes.
	localparam logic [1:0] OP_TRANSLATE = 2'd0;
	localparam logic [1:0] OP_PTE_RESP  = 2'd1;
	localparam logic [1:0] OP_FLUSH     = 2'd2;

	// Access kinds. Kind three is handled as a store.
	localparam logic [1:0] ACC_FETCH = 2'd0;
	localparam logic [1:0] ACC_LOAD  = 2'd1;
	localparam logic [1:0] ACC_STORE = 2'd2;
	localparam logic [1:0] ACC_ALIAS = 2'd3;

	// Privilege levels.
	localparam logic [1:0] PRIV_M = 2'd3;

	// Result kinds.
	localparam logic [2:0] RK_OK      = 3'd0;
	localparam logic [2:0] RK_READ    = 3'd1;
	localparam logic [2:0] RK_RETRY   = 3'd2;
	localparam logic [2:0] RK_PFAULT  = 3'd3;
	localparam logic [2:0] RK_AFAULT  = 3'd4;
	localparam logic [2:0] RK_FLUSHED = 3'd5;

	// Configuration register indexes.
	localparam logic [1:0] REG_PAGING_ENABLE = 2'd0;
	localparam logic [1:0] REG_ROOT_PPN      = 2'd1;
	localparam logic [1:0] REG_MODIFY_PRIV   = 2'd2;
	localparam logic [1:0] REG_SAVED_PRIV    = 2'd3;

	// Walk levels.
	localparam logic [1:0] LEVEL_TOP = 2'd2;
	localparam logic [1:0] LEVEL_MID = 2'd1;
	localparam logic [1:0] LEVEL_LOW = 2'd0;

	// One TLB entry: the virtual page number and the offset to add.
	typedef struct packed {
		logic [TAG_W-1:0] tag;
		logic [VA_W-1:0]  offset;
	} tlb_entry_t;

	// Write forwarded from the previous cycle, covering the RAM read that
	// happened at the same edge as the write.
	typedef struct packed {
		logic             vld;
		logic [IDX_W-1:0] idx;
		tlb_entry_t       entry;
	} tlb_fwd_t;

	localparam int ENTRY_W = $bits(tlb_entry_t);

endpackage

[rtl/sv39ptw_ram.sv]
// Generic single-write, single-read RAM with a registered, read-first read port.
// Depends on nothing; instanced for the TLB entry stores.
module sv39ptw_ram #(
	parameter int WIDTH = 116,
	parameter int DEPTH = 64
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port and registered read; a read at the written address sees old data.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[rtl/sv39_tlb_page_table_walker.sv]
// Sv39 translation unit: fetch, load and store TLBs and a one-PTE-at-a-time walker.
// Depends on sv39ptw_pkg and sv39ptw_ram.
//
// Channel   Ports                                           Transfer
// input     operation vaddr access_kind priv_mode           edge with start high, busy low
//           pte_data pte_error
// result    result_kind out_addr out_access                 edge that ends a cycle with done
// config    cfg_we cfg_index cfg_wdata                      edge with cfg_we high
//
// One item is taken every cycle; busy never rises.
// An item is registered in the input stage, together with the registered TLB RAM read,
// and then in the result register, which strobes its result on done.
// Reset clears the valid bits and the walk state at once; there is no clearing pass.
// The receiver cannot stall, so results never wait and never hold off input.
module sv39_tlb_page_table_walker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  operation,
	input  logic [63:0] vaddr,
	input  logic [1:0]  access_kind,
	input  logic [1:0]  priv_mode,
	input  logic [63:0] pte_data,
	input  logic        pte_error,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [43:0] cfg_wdata,
	output logic        done,
	output logic [2:0]  result_kind,
	output logic [63:0] out_addr,
	output logic [1:0]  out_access
);

	localparam int N     = sv39ptw_pkg::TLB_ENTRIES;
	localparam int IW    = sv39ptw_pkg::IDX_W;
	localparam int PW    = sv39ptw_pkg::PPN_W;
	localparam int SH    = sv39ptw_pkg::PG_SHIFT;
	localparam int EW    = sv39ptw_pkg::ENTRY_W;

	// Configuration registers.
	logic          paging_q;
	logic [PW-1:0] root_ppn_q;
	logic          mprv_q;
	logic [1:0]    mpp_q;

	// Input stage.
	logic        vld_s1;
	logic [1:0]  op_s1;
	logic [63:0] va_s1;
	logic [1:0]  acc_s1;
	logic [1:0]  priv_s1;
	logic [63:0] pte_s1;
	logic        pterr_s1;

	// Walk state.
	logic        walk_busy_q;
	logic [63:0] walk_vaddr_q;
	logic [1:0]  walk_level_q;
	logic [1:0]  walk_access_q;

	// Valid bits.
	logic [N-1:0] fetch_valid_q;
	logic [N-1:0] load_valid_q;
	logic [N-1:0] store_valid_q;

	// Result register.
	logic        done_q;
	logic [2:0]  result_kind_q;
	logic [63:0] out_addr_q;
	logic [1:0]  out_access_q;

	logic                   accept;
	logic [1:0]             acc_in;
	logic [EW-1:0]          f_rdata;
	logic [EW-1:0]          d_rdata;
	sv39ptw_pkg::tlb_fwd_t  f_fwd_q;
	sv39ptw_pkg::tlb_fwd_t  d_fwd_q;
	sv39ptw_pkg::tlb_entry_t f_entry;
	sv39ptw_pkg::tlb_entry_t d_entry;

	// Next-state and write controls from the single-pass logic.
	logic                    res_vld;
	logic [2:0]              res_kind;
	logic [63:0]             res_addr;
	logic [1:0]              res_acc;
	logic                    walk_busy_d;
	logic [63:0]             walk_vaddr_d;
	logic [1:0]              walk_level_d;
	logic [1:0]              walk_access_d;
	logic                    f_we;
	logic                    d_we;
	logic [IW-1:0]           w_idx;
	sv39ptw_pkg::tlb_entry_t w_entry;
	logic                    ld_v;
	logic                    st_v;
	logic                    flush_all;

	// Datapath helpers.
	logic [IW-1:0] idx_s1;
	logic [IW-1:0] walk_idx;
	logic [1:0]    mode;
	logic          f_hit;
	logic          l_hit;
	logic          s_hit;
	logic          pv, pr, pw, px, pa, pd;
	logic          bad_pte;
	logic          misaligned;
	logic [PW-1:0] leaf_ppn;
	logic [63:0]   leaf_page;
	logic [63:0]   leaf_off;
	logic [8:0]    next_vpn;
	logic          leaf_fault;

	assign accept = start && !busy;
	assign busy   = 1'b0;
	assign acc_in = (access_kind == sv39ptw_pkg::ACC_ALIAS) ? sv39ptw_pkg::ACC_STORE
	                                                         : access_kind;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			paging_q   <= 1'b0;
			root_ppn_q <= '0;
			mprv_q     <= 1'b0;
			mpp_q      <= 2'd0;
		end else if (cfg_we) begin
			case (cfg_index)
				sv39ptw_pkg::REG_PAGING_ENABLE: paging_q   <= cfg_wdata[0];
				sv39ptw_pkg::REG_ROOT_PPN:      root_ppn_q <= cfg_wdata;
				sv39ptw_pkg::REG_MODIFY_PRIV:   mprv_q     <= cfg_wdata[0];
				sv39ptw_pkg::REG_SAVED_PRIV:    mpp_q      <= cfg_wdata[1:0];
				default: ;
			endcase
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1    <= operation;
			va_s1    <= vaddr;
			acc_s1   <= acc_in;
			priv_s1  <= priv_mode;
			pte_s1   <= pte_data;
			pterr_s1 <= pte_error;
		end
	end

	// TLB entry stores: fetch, and the shared load/store store.
	sv39ptw_ram #(
		.WIDTH(EW),
		.DEPTH(N)
	) u_fetch_ram (
		.clk   (clk),
		.we    (f_we),
		.waddr (w_idx),
		.wdata (w_entry),
		.re    (accept),
		.raddr (vaddr[SH +: IW]),
		.rdata (f_rdata)
	);

	sv39ptw_ram #(
		.WIDTH(EW),
		.DEPTH(N)
	) u_data_ram (
		.clk   (clk),
		.we    (d_we),
		.waddr (w_idx),
		.wdata (w_entry),
		.re    (accept),
		.raddr (vaddr[SH +: IW]),
		.rdata (d_rdata)
	);

	// Forward a write made at the edge where the current item read the RAM.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			f_fwd_q <= '0;
			d_fwd_q <= '0;
		end else begin
			f_fwd_q.vld   <= f_we;
			f_fwd_q.idx   <= w_idx;
			f_fwd_q.entry <= w_entry;
			d_fwd_q.vld   <= d_we;
			d_fwd_q.idx   <= w_idx;
			d_fwd_q.entry <= w_entry;
		end
	end

	assign idx_s1   = va_s1[SH +: IW];
	assign walk_idx = walk_vaddr_q[SH +: IW];
	assign f_entry  = (f_fwd_q.vld && f_fwd_q.idx == idx_s1) ? f_fwd_q.entry : f_rdata;
	assign d_entry  = (d_fwd_q.vld && d_fwd_q.idx == idx_s1) ? d_fwd_q.entry : d_rdata;

	// Lookup and privilege.
	assign f_hit = fetch_valid_q[idx_s1] && (f_entry.tag == va_s1[63:SH]);
	assign l_hit = load_valid_q[idx_s1] && (d_entry.tag == va_s1[63:SH]);
	assign s_hit = store_valid_q[idx_s1] && (d_entry.tag == va_s1[63:SH]);
	assign mode  = (mprv_q && acc_s1 != sv39ptw_pkg::ACC_FETCH) ? mpp_q : priv_s1;

	// PTE decode, superpage alignment and the leaf mapping.
	assign pv      = pte_s1[0];
	assign pr      = pte_s1[1];
	assign pw      = pte_s1[2];
	assign px      = pte_s1[3];
	assign pa      = pte_s1[6];
	assign pd      = pte_s1[7];
	assign bad_pte = !pv || (!pr && pw) || (pte_s1[63:54] != 10'd0);

	always_comb begin
		misaligned = 1'b0;
		leaf_ppn   = pte_s1[53:10];
		next_vpn   = walk_vaddr_q[29:21];
		case (walk_level_q)
			sv39ptw_pkg::LEVEL_TOP: begin
				misaligned = (pte_s1[27:10] != 18'd0);
				leaf_ppn   = {pte_s1[53:28], walk_vaddr_q[29:12]};
				next_vpn   = walk_vaddr_q[29:21];
			end
			sv39ptw_pkg::LEVEL_MID: begin
				misaligned = (pte_s1[18:10] != 9'd0);
				leaf_ppn   = {pte_s1[53:19], walk_vaddr_q[20:12]};
				next_vpn   = walk_vaddr_q[20:12];
			end
			default: begin
				misaligned = 1'b0;
				leaf_ppn   = pte_s1[53:10];
				next_vpn   = walk_vaddr_q[20:12];
			end
		endcase
	end

	assign leaf_page = {8'd0, leaf_ppn, 12'd0};
	assign leaf_off  = leaf_page - {walk_vaddr_q[63:SH], 12'd0};

	always_comb begin
		if (walk_access_q == sv39ptw_pkg::ACC_FETCH) begin
			leaf_fault = !pa || !px;
		end else if (walk_access_q == sv39ptw_pkg::ACC_LOAD) begin
			leaf_fault = !pa || !pr;
		end else begin
			leaf_fault = !pa || !pw || !pd;
		end
	end

	// Single-pass handling of the item in the input stage.
	always_comb begin
		res_vld       = 1'b0;
		res_kind      = sv39ptw_pkg::RK_OK;
		res_addr      = va_s1;
		res_acc       = acc_s1;
		walk_busy_d   = walk_busy_q;
		walk_vaddr_d  = walk_vaddr_q;
		walk_level_d  = walk_level_q;
		walk_access_d = walk_access_q;
		f_we          = 1'b0;
		d_we          = 1'b0;
		w_idx         = idx_s1;
		w_entry.tag   = va_s1[63:SH];
		w_entry.offset = 64'd0;
		ld_v          = 1'b1;
		st_v          = 1'b1;
		flush_all     = 1'b0;
		if (vld_s1) begin
			case (op_s1)
				sv39ptw_pkg::OP_TRANSLATE: begin
					res_vld = 1'b1;
					if (acc_s1 == sv39ptw_pkg::ACC_FETCH && f_hit) begin
						res_addr = va_s1 + f_entry.offset;
					end else if ((acc_s1 == sv39ptw_pkg::ACC_LOAD && l_hit) ||
							(acc_s1 == sv39ptw_pkg::ACC_STORE && s_hit)) begin
						res_addr = va_s1 + d_entry.offset;
					end else if (mode == sv39ptw_pkg::PRIV_M || !paging_q) begin
						// Identity mapping, cached with a zero offset.
						f_we = (acc_s1 == sv39ptw_pkg::ACC_FETCH);
						d_we = (acc_s1 != sv39ptw_pkg::ACC_FETCH);
					end else if (walk_busy_q) begin
						res_kind = sv39ptw_pkg::RK_RETRY;
					end else begin
						res_kind      = sv39ptw_pkg::RK_READ;
						res_addr      = {8'd0, root_ppn_q, va_s1[38:30], 3'd0};
						walk_busy_d   = 1'b1;
						walk_vaddr_d  = va_s1;
						walk_level_d  = sv39ptw_pkg::LEVEL_TOP;
						walk_access_d = acc_s1;
					end
				end
				sv39ptw_pkg::OP_PTE_RESP: begin
					if (walk_busy_q) begin
						res_vld        = 1'b1;
						res_addr       = walk_vaddr_q;
						res_acc        = walk_access_q;
						w_idx          = walk_idx;
						w_entry.tag    = walk_vaddr_q[63:SH];
						w_entry.offset = leaf_off;
						ld_v           = pr;
						st_v           = pw && pd;
						if (pterr_s1) begin
							res_kind    = sv39ptw_pkg::RK_AFAULT;
							walk_busy_d = 1'b0;
						end else if (bad_pte) begin
							res_kind    = sv39ptw_pkg::RK_PFAULT;
							walk_busy_d = 1'b0;
						end else if (pr || px) begin
							// Leaf: check alignment and permissions, then fill.
							walk_busy_d = 1'b0;
							if (misaligned || leaf_fault) begin
								res_kind = sv39ptw_pkg::RK_PFAULT;
							end else begin
								res_kind = sv39ptw_pkg::RK_OK;
								res_addr = {leaf_page[63:SH], walk_vaddr_q[SH-1:0]};
								f_we     = (walk_access_q == sv39ptw_pkg::ACC_FETCH);
								d_we     = (walk_access_q != sv39ptw_pkg::ACC_FETCH);
							end
						end else if (walk_level_q == sv39ptw_pkg::LEVEL_LOW) begin
							res_kind    = sv39ptw_pkg::RK_PFAULT;
							walk_busy_d = 1'b0;
						end else begin
							// Pointer: descend one level.
							res_kind     = sv39ptw_pkg::RK_READ;
							res_addr     = {8'd0, pte_s1[53:10], next_vpn, 3'd0};
							walk_level_d = walk_level_q - 2'd1;
						end
					end
				end
				sv39ptw_pkg::OP_FLUSH: begin
					res_vld   = 1'b1;
					res_kind  = sv39ptw_pkg::RK_FLUSHED;
					res_addr  = 64'd0;
					res_acc   = sv39ptw_pkg::ACC_FETCH;
					flush_all = 1'b1;
				end
				default: ;
			endcase
		end
	end

	// Walk state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walk_busy_q   <= 1'b0;
			walk_vaddr_q  <= 64'd0;
			walk_level_q  <= sv39ptw_pkg::LEVEL_LOW;
			walk_access_q <= sv39ptw_pkg::ACC_FETCH;
		end else begin
			walk_busy_q   <= walk_busy_d;
			walk_vaddr_q  <= walk_vaddr_d;
			walk_level_q  <= walk_level_d;
			walk_access_q <= walk_access_d;
		end
	end

	// Valid bits: a flush or any configuration write clears them all.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fetch_valid_q <= '0;
			load_valid_q  <= '0;
			store_valid_q <= '0;
		end else if (flush_all || cfg_we) begin
			fetch_valid_q <= '0;
			load_valid_q  <= '0;
			store_valid_q <= '0;
		end else begin
			if (f_we) begin
				fetch_valid_q[w_idx] <= 1'b1;
			end
			if (d_we) begin
				load_valid_q[w_idx]  <= ld_v;
				store_valid_q[w_idx] <= st_v;
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= res_vld;
		end
	end

	always_ff @(posedge clk) begin
		result_kind_q <= res_kind;
		out_addr_q    <= res_addr;
		out_access_q  <= res_acc;
	end

	assign done        = done_q;
	assign result_kind = result_kind_q;
	assign out_addr    = out_addr_q;
	assign out_access  = out_access_q;

	// A PTE read is only issued with a walk in progress.
	assert property (@(posedge clk) disable iff (!arst_n)
		done_q && result_kind_q == sv39ptw_pkg::RK_READ |-> walk_busy_q)
		else $error("PTE read result without a walk in progress");

	// A retry is only given while the walker is busy.
	assert property (@(posedge clk) disable iff (!arst_n)
		done_q && result_kind_q == sv39ptw_pkg::RK_RETRY |-> walk_busy_q)
		else $error("retry result with the walker idle");

	// The walk level stays within the three Sv39 levels.
	assert property (@(posedge clk) disable iff (!arst_n)
		walk_busy_q |-> walk_level_q <= sv39ptw_pkg::LEVEL_TOP)
		else $error("walk level out of range");

	// A flush is acknowledged in the following cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && op_s1 == sv39ptw_pkg::OP_FLUSH
		|=> done_q && result_kind_q == sv39ptw_pkg::RK_FLUSHED)
		else $error("flush not acknowledged");

endmodule

[sim/tb_sv39_tlb_page_table_walker.sv]
// Self-checking testbench for the Sv39 translation unit: directed and random requests,
// PTE responses, flushes and register writes, checked against a built-in predictor.
// Depends on sv39ptw_pkg and sv39_tlb_page_table_walker.
module tb_sv39_tlb_page_table_walker;
	timeunit 1ns;
	timeprecision 1ps;

	// Geometry taken from the package.
	localparam int TLB_ENTRIES = sv39ptw_pkg::TLB_ENTRIES;
	localparam int IDX_W       = sv39ptw_pkg::IDX_W;
	localparam int TAG_W       = sv39ptw_pkg::TAG_W;
	localparam int PPN_W       = sv39ptw_pkg::PPN_W;
	localparam int PG_SHIFT    = sv39ptw_pkg::PG_SHIFT;
	localparam int VPN_W       = sv39ptw_pkg::VPN_W;

	// Encodings the package leaves unnamed.
	localparam logic [1:0] OP_IGNORED = 2'd3;
	localparam logic [1:0] PRIV_U     = 2'd0;
	localparam logic [1:0] PRIV_S     = 2'd1;
	localparam logic [1:0] PRIV_H     = 2'd2;

	// PTE flag masks.
	localparam logic [7:0] PTE_V = 8'h01;
	localparam logic [7:0] PTE_R = 8'h02;
	localparam logic [7:0] PTE_W = 8'h04;
	localparam logic [7:0] PTE_X = 8'h08;
	localparam logic [7:0] PTE_U = 8'h10;
	localparam logic [7:0] PTE_G = 8'h20;
	localparam logic [7:0] PTE_A = 8'h40;
	localparam logic [7:0] PTE_D = 8'h80;

	localparam logic [PPN_W-1:0] PPN_MAX = '1;
	localparam int PTE_BYTES     = 8;
	localparam int SETTLE_CYCLES = 6;
	localparam int POOL          = 8;

	typedef struct {
		logic [1:0]  op;
		logic [63:0] va;
		logic [1:0]  acc;
		logic [1:0]  priv;
		logic [63:0] pte;
		logic        err;
	} cmd_t;

	typedef struct {
		logic [2:0]  kind;
		logic [63:0] addr;
		logic [1:0]  acc;
	} xlat_t;

	logic        clk;
	logic        arst_n      = 1'b0;
	logic        start       = 1'b0;
	logic        busy;
	logic [1:0]  operation   = OP_IGNORED;
	logic [63:0] vaddr       = '0;
	logic [1:0]  access_kind = sv39ptw_pkg::ACC_FETCH;
	logic [1:0]  priv_mode   = PRIV_U;
	logic [63:0] pte_data    = '0;
	logic        pte_error   = 1'b0;
	logic        cfg_we      = 1'b0;
	logic [1:0]  cfg_index   = sv39ptw_pkg::REG_PAGING_ENABLE;
	logic [43:0] cfg_wdata   = '0;
	logic        done;
	logic [2:0]  result_kind;
	logic [63:0] out_addr;
	logic [1:0]  out_access;

	cmd_t  cmd_q[$];
	xlat_t xlat_q[$];
	int    idle_pct = 0;
	int    n_items  = 0;
	bit    failed   = 1'b0;

	logic [TAG_W-1:0] page_pool[POOL];

	// Predictor state: registers, the three TLBs and the walker.
	bit               m_paging;
	bit [PPN_W-1:0]   m_root;
	bit               m_mprv;
	bit [1:0]         m_mpp;
	bit               fetch_vld[TLB_ENTRIES];
	bit               load_vld[TLB_ENTRIES];
	bit               store_vld[TLB_ENTRIES];
	bit [TAG_W-1:0]   fetch_tag[TLB_ENTRIES];
	bit [TAG_W-1:0]   load_tag[TLB_ENTRIES];
	bit [TAG_W-1:0]   store_tag[TLB_ENTRIES];
	bit [63:0]        fetch_off[TLB_ENTRIES];
	bit [63:0]        data_off[TLB_ENTRIES];
	bit               walking;
	bit [63:0]        walk_va;
	int               walk_lvl;
	bit [1:0]         walk_acc;

	sv39_tlb_page_table_walker u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.operation   (operation),
		.vaddr       (vaddr),
		.access_kind (access_kind),
		.priv_mode   (priv_mode),
		.pte_data    (pte_data),
		.pte_error   (pte_error),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.done        (done),
		.result_kind (result_kind),
		.out_addr    (out_addr),
		.out_access  (out_access)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// ---------------------------------------------------------------- predictor

	function automatic void flush_tlbs();
		foreach (fetch_vld[i]) begin
			fetch_vld[i] = 1'b0;
			load_vld[i]  = 1'b0;
			store_vld[i] = 1'b0;
		end
	endfunction

	function automatic xlat_t mk(logic [2:0] kind, logic [63:0] addr, logic [1:0] acc);
		xlat_t r;
		r.kind = kind;
		r.addr = addr;
		r.acc  = acc;
		return r;
	endfunction

	function automatic xlat_t end_walk(logic [2:0] kind);
		walking = 1'b0;
		return mk(kind, walk_va, walk_acc);
	endfunction

	// Nine-bit slice of the virtual page number used at a given level.
	function automatic logic [63:0] vpn_of(logic [63:0] va, int lvl);
		return (va >> (PG_SHIFT + VPN_W * lvl)) & ((64'd1 << VPN_W) - 1);
	endfunction

	// One PTE of the walk in progress: fault, descend a level, or fill a TLB.
	function automatic xlat_t walk_pte(logic [63:0] pte);
		logic [63:0]      page;
		logic [63:0]      low;
		logic [63:0]      off;
		logic [TAG_W-1:0] tag;
		logic [IDX_W-1:0] idx;
		logic             v, r, w, x, a, d;
		v    = |(pte[7:0] & PTE_V);
		r    = |(pte[7:0] & PTE_R);
		w    = |(pte[7:0] & PTE_W);
		x    = |(pte[7:0] & PTE_X);
		a    = |(pte[7:0] & PTE_A);
		d    = |(pte[7:0] & PTE_D);
		page = {8'd0, pte[53:10], 12'd0};
		if (!v || (!r && w) || pte[63:54] != '0) begin
			return end_walk(sv39ptw_pkg::RK_PFAULT);
		end
		if (r || x) begin
			// Superpages must be aligned; the low VPN bits come from the address.
			if (walk_lvl > 0) begin
				low = (64'd1 << (VPN_W * walk_lvl)) - 1;
				if (((page >> PG_SHIFT) & low) != 0) begin
					return end_walk(sv39ptw_pkg::RK_PFAULT);
				end
				page += ((walk_va >> PG_SHIFT) & low) << PG_SHIFT;
			end
			tag = walk_va[63:PG_SHIFT];
			idx = tag[IDX_W-1:0];
			off = page - {tag, {PG_SHIFT{1'b0}}};
			if (walk_acc == sv39ptw_pkg::ACC_FETCH) begin
				if (!a || !x) begin
					return end_walk(sv39ptw_pkg::RK_PFAULT);
				end
				fetch_vld[idx] = 1'b1;
				fetch_tag[idx] = tag;
				fetch_off[idx] = off;
			end else begin
				if (!a || (walk_acc == sv39ptw_pkg::ACC_LOAD && !r) ||
				    (walk_acc != sv39ptw_pkg::ACC_LOAD && (!w || !d))) begin
					return end_walk(sv39ptw_pkg::RK_PFAULT);
				end
				load_vld[idx]  = r;
				load_tag[idx]  = tag;
				store_vld[idx] = w && d;
				store_tag[idx] = tag;
				data_off[idx]  = off;
			end
			walking = 1'b0;
			return mk(sv39ptw_pkg::RK_OK, walk_va + off, walk_acc);
		end
		if (walk_lvl == 0) begin
			return end_walk(sv39ptw_pkg::RK_PFAULT);
		end
		walk_lvl--;
		return mk(sv39ptw_pkg::RK_READ, page + vpn_of(walk_va, walk_lvl) * PTE_BYTES,
		          walk_acc);
	endfunction

	// TLB lookup, then identity mapping, then retry or the start of a walk.
	function automatic xlat_t tlb_translate(logic [63:0] va, logic [1:0] acc, logic [1:0] priv);
		logic [TAG_W-1:0] tag;
		logic [IDX_W-1:0] idx;
		logic [1:0]       mode;
		tag  = va[63:PG_SHIFT];
		idx  = tag[IDX_W-1:0];
		mode = priv;
		case (acc)
			sv39ptw_pkg::ACC_FETCH: begin
				if (fetch_vld[idx] && fetch_tag[idx] == tag) begin
					return mk(sv39ptw_pkg::RK_OK, va + fetch_off[idx], acc);
				end
			end
			sv39ptw_pkg::ACC_LOAD: begin
				if (load_vld[idx] && load_tag[idx] == tag) begin
					return mk(sv39ptw_pkg::RK_OK, va + data_off[idx], acc);
				end
			end
			default: begin
				if (store_vld[idx] && store_tag[idx] == tag) begin
					return mk(sv39ptw_pkg::RK_OK, va + data_off[idx], acc);
				end
			end
		endcase
		if (m_mprv && acc != sv39ptw_pkg::ACC_FETCH) begin
			mode = m_mpp;
		end
		if (mode == sv39ptw_pkg::PRIV_M || !m_paging) begin
			if (acc == sv39ptw_pkg::ACC_FETCH) begin
				fetch_vld[idx] = 1'b1;
				fetch_tag[idx] = tag;
				fetch_off[idx] = '0;
			end else begin
				load_vld[idx]  = 1'b1;
				load_tag[idx]  = tag;
				store_vld[idx] = 1'b1;
				store_tag[idx] = tag;
				data_off[idx]  = '0;
			end
			return mk(sv39ptw_pkg::RK_OK, va, acc);
		end
		if (walking) begin
			return mk(sv39ptw_pkg::RK_RETRY, va, acc);
		end
		walking  = 1'b1;
		walk_va  = va;
		walk_lvl = sv39ptw_pkg::LEVEL_TOP;
		walk_acc = acc;
		return mk(sv39ptw_pkg::RK_READ,
		          {8'd0, m_root, 12'd0} + vpn_of(va, walk_lvl) * PTE_BYTES, acc);
	endfunction

	// Returns 1 with the expected result when the item produces one.
	function automatic bit predict_item(input cmd_t c, output xlat_t r);
		logic [1:0] acc;
		acc = (c.acc == sv39ptw_pkg::ACC_ALIAS) ? sv39ptw_pkg::ACC_STORE : c.acc;
		case (c.op)
			sv39ptw_pkg::OP_TRANSLATE: begin
				r = tlb_translate(c.va, acc, c.priv);
				return 1'b1;
			end
			sv39ptw_pkg::OP_PTE_RESP: begin
				if (!walking) begin
					return 1'b0;
				end
				r = c.err ? end_walk(sv39ptw_pkg::RK_AFAULT) : walk_pte(c.pte);
				return 1'b1;
			end
			sv39ptw_pkg::OP_FLUSH: begin
				flush_tlbs();
				r = mk(sv39ptw_pkg::RK_FLUSHED, '0, sv39ptw_pkg::ACC_FETCH);
				return 1'b1;
			end
			default: begin
				return 1'b0;
			end
		endcase
	endfunction

	// ---------------------------------------------------------------- driver and monitor

	// Present the head of the command queue; drop it once the block takes the transfer.
	always @(posedge clk) begin : driver
		cmd_t  taken;
		xlat_t res;
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy) begin
				taken = cmd_q.pop_front();
				if (predict_item(taken, res)) begin
					xlat_q.push_back(res);
				end
			end
			if (!(start && busy)) begin
				if (cmd_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
					start       <= 1'b1;
					operation   <= cmd_q[0].op;
					vaddr       <= cmd_q[0].va;
					access_kind <= cmd_q[0].acc;
					priv_mode   <= cmd_q[0].priv;
					pte_data    <= cmd_q[0].pte;
					pte_error   <= cmd_q[0].err;
				end else begin
					// Idle cycle: the payload carries junk that must be ignored.
					start       <= 1'b0;
					operation   <= 2'($urandom);
					vaddr       <= {$urandom, $urandom};
					access_kind <= 2'($urandom);
					priv_mode   <= 2'($urandom);
					pte_data    <= {$urandom, $urandom};
					pte_error   <= 1'($urandom);
				end
			end
		end
	end

	// Compare every result transfer with the oldest expectation.
	always @(posedge clk) begin : monitor
		xlat_t want;
		if (arst_n && done) begin
			if (xlat_q.size() == 0) begin
				$error("unexpected result: kind %0d addr %h access %0d",
				       result_kind, out_addr, out_access);
				failed = 1'b1;
			end else begin
				want = xlat_q.pop_front();
				if (result_kind !== want.kind) begin
					$error("result_kind: expected %0d, got %0d", want.kind, result_kind);
					failed = 1'b1;
				end
				if (out_addr !== want.addr) begin
					$error("out_addr: expected %h, got %h", want.addr, out_addr);
					failed = 1'b1;
				end
				if (out_access !== want.acc) begin
					$error("out_access: expected %0d, got %0d", want.acc, out_access);
					failed = 1'b1;
				end
			end
		end
	end

	// ---------------------------------------------------------------- stimulus

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic void add(logic [1:0] op, logic [63:0] va, logic [1:0] acc,
	                            logic [1:0] priv, logic [63:0] pte, logic err);
		cmd_t c;
		c.op   = op;
		c.va   = va;
		c.acc  = acc;
		c.priv = priv;
		c.pte  = pte;
		c.err  = err;
		cmd_q.push_back(c);
		n_items++;
	endfunction

	function automatic void add_xlat(logic [63:0] va, logic [1:0] acc, logic [1:0] priv);
		add(sv39ptw_pkg::OP_TRANSLATE, va, acc, priv, rand64(), 1'($urandom));
	endfunction

	function automatic void add_pte(logic [63:0] pte, logic err);
		add(sv39ptw_pkg::OP_PTE_RESP, rand64(), 2'($urandom), 2'($urandom), pte, err);
	endfunction

	function automatic void add_misc(logic [1:0] op);
		add(op, rand64(), 2'($urandom), 2'($urandom), rand64(), 1'($urandom));
	endfunction

	// Pointer PTE: valid, no R/W/X, other flags random.
	function automatic logic [63:0] ptr_pte(logic [PPN_W-1:0] ppn);
		logic [7:0] fl;
		fl = PTE_V | (8'($urandom) & (PTE_U | PTE_G | PTE_A | PTE_D));
		return {10'd0, ppn, 2'($urandom), fl};
	endfunction

	// Leaf PTE, mostly aligned and with the permissions the access needs.
	function automatic logic [63:0] leaf_pte(int lvl, logic [1:0] acc);
		logic [PPN_W-1:0] ppn;
		logic [7:0]       fl;
		logic [9:0]       rsv;
		ppn = PPN_W'(rand64());
		if ($urandom_range(9) != 0) begin
			ppn &= ~((44'd1 << (VPN_W * lvl)) - 1);
		end
		if ($urandom_range(4) != 0) begin
			case (acc)
				sv39ptw_pkg::ACC_FETCH: fl = PTE_X | PTE_A;
				sv39ptw_pkg::ACC_LOAD:  fl = PTE_R | PTE_A;
				default:                fl = PTE_R | PTE_W | PTE_A | PTE_D;
			endcase
			fl |= PTE_V | (8'($urandom) & (PTE_R | PTE_X | PTE_U | PTE_G | PTE_D));
			if ((fl & PTE_R) != 0 && $urandom_range(1) == 1) begin
				fl |= PTE_W;
			end
		end else begin
			fl = 8'($urandom);
		end
		rsv = ($urandom_range(15) == 0) ? 10'($urandom) : 10'd0;
		return {rsv, ppn, 2'($urandom), fl};
	endfunction

	// Addresses mostly come from a small set of pages so that TLB hits and
	// index conflicts happen.
	function automatic logic [63:0] pick_va();
		if ($urandom_range(3) == 0) begin
			return rand64();
		end
		return {page_pool[$urandom_range(POOL - 1)], 12'($urandom)};
	endfunction

	function automatic logic [1:0] pick_priv();
		return ($urandom_range(9) == 0) ? sv39ptw_pkg::PRIV_M : 2'($urandom_range(2));
	endfunction

	function automatic void gen_noise();
		case ($urandom_range(4))
			0:       add_xlat(pick_va(), 2'($urandom), 2'($urandom));
			1:       add_misc(sv39ptw_pkg::OP_FLUSH);
			2:       add_misc(OP_IGNORED);
			3:       add_pte(rand64(), 1'($urandom));
			default: add_misc(2'($urandom));
		endcase
	endfunction

	// A translate request followed by a plausible chain of PTE responses.
	function automatic void gen_walk();
		logic [63:0] va;
		logic [1:0]  acc;
		int          ptrs;
		va   = pick_va();
		acc  = 2'($urandom);
		add_xlat(va, acc, pick_priv());
		ptrs = ($urandom_range(15) == 0) ? 3 : $urandom_range(2);
		for (int k = 0; k <= ptrs && k < 3; k++) begin
			if ($urandom_range(7) == 0) begin
				gen_noise();
			end
			if ($urandom_range(19) == 0) begin
				add_pte(rand64(), 1'b1);
			end else if ($urandom_range(19) == 0) begin
				add_pte(rand64(), 1'b0);
			end else if (k < ptrs) begin
				add_pte(ptr_pte(PPN_W'(rand64())), 1'b0);
			end else begin
				add_pte(leaf_pte(sv39ptw_pkg::LEVEL_TOP - k, acc), 1'b0);
			end
		end
	endfunction

	// Wait until every transfer is taken and every result has come back.
	task automatic settle();
		do @(negedge clk);
		while (cmd_q.size() != 0 || xlat_q.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [43:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		case (idx)
			sv39ptw_pkg::REG_PAGING_ENABLE: m_paging = val[0];
			sv39ptw_pkg::REG_ROOT_PPN:      m_root   = val;
			sv39ptw_pkg::REG_MODIFY_PRIV:   m_mprv   = val[0];
			default:                        m_mpp    = val[1:0];
		endcase
		flush_tlbs();
	endtask

	task automatic set_config(logic pg, logic [PPN_W-1:0] root, logic mprv, logic [1:0] mpp);
		write_reg(sv39ptw_pkg::REG_PAGING_ENABLE, 44'(pg));
		write_reg(sv39ptw_pkg::REG_ROOT_PPN, root);
		write_reg(sv39ptw_pkg::REG_MODIFY_PRIV, 44'(mprv));
		write_reg(sv39ptw_pkg::REG_SAVED_PRIV, 44'(mpp));
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic run_phase(int pct, int n);
		int target;
		@(negedge clk);
		idle_pct = pct;
		target   = n_items + n;
		while (n_items < target) begin
			if ($urandom_range(4) != 0) begin
				gen_walk();
			end else begin
				gen_noise();
			end
		end
		settle();
	endtask

	initial begin
		// Page pool: the extremes plus pages that share a few TLB indexes.
		page_pool[0] = '0;
		page_pool[1] = '1;
		for (int i = 2; i < POOL; i++) begin
			page_pool[i] = {(TAG_W - IDX_W)'(rand64()), IDX_W'($urandom_range(3))};
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Bare mode after reset: identity mappings, hits, ignored items, flush.
		@(negedge clk);
		add_xlat(64'd0, sv39ptw_pkg::ACC_FETCH, PRIV_U);
		add_xlat('1, sv39ptw_pkg::ACC_LOAD, PRIV_S);
		add_xlat('1, sv39ptw_pkg::ACC_LOAD, PRIV_S);
		add_xlat(64'h8000_0000_0000_1234, sv39ptw_pkg::ACC_ALIAS, PRIV_U);
		add_misc(OP_IGNORED);
		add_pte(rand64(), 1'b0);
		add_misc(sv39ptw_pkg::OP_FLUSH);
		settle();

		// Sv39 with the highest root page: retry, flush and bus error during a
		// walk, non-leaf at the last level, reserved bits, misaligned and
		// wrapping superpages, then hits on the filled entries.
		set_config(1'b1, PPN_MAX, 1'b0, PRIV_U);
		@(negedge clk);
		add_xlat(64'h0000_003F_C020_1008, sv39ptw_pkg::ACC_LOAD, PRIV_S);
		add_xlat(64'h0000_0012_3456_7000, sv39ptw_pkg::ACC_STORE, PRIV_U);
		add_xlat(64'h0000_0012_3456_7000, sv39ptw_pkg::ACC_FETCH, sv39ptw_pkg::PRIV_M);
		add_misc(sv39ptw_pkg::OP_FLUSH);
		add_pte(rand64(), 1'b1);
		add_xlat(64'hFFFF_FFFF_FFFF_F000, sv39ptw_pkg::ACC_FETCH, PRIV_U);
		add_pte(ptr_pte(PPN_MAX), 1'b0);
		add_pte(ptr_pte(PPN_MAX), 1'b0);
		add_pte(ptr_pte(44'd0), 1'b0);
		add_xlat(64'h0000_0000_4000_0010, sv39ptw_pkg::ACC_STORE, PRIV_S);
		add_pte({10'h200, 44'h0000_0040_000, 2'd0, PTE_D | PTE_A | PTE_X | PTE_W | PTE_R | PTE_V},
		        1'b0);
		add_xlat(64'h0000_0000_8000_0020, sv39ptw_pkg::ACC_LOAD, PRIV_U);
		add_pte({10'd0, 44'd1, 2'd0, PTE_A | PTE_R | PTE_V}, 1'b0);
		add_xlat(64'h0000_007F_FFFF_F7F8, sv39ptw_pkg::ACC_STORE, PRIV_S);
		add_pte({10'd0, 44'hFFF_FFFC_0000, 2'b11,
		         PTE_D | PTE_A | PTE_X | PTE_W | PTE_R | PTE_V}, 1'b0);
		add_xlat(64'h0000_007F_FFFF_F000, sv39ptw_pkg::ACC_STORE, PRIV_U);
		add_xlat(64'h0000_007F_FFFF_FFFF, sv39ptw_pkg::ACC_LOAD, PRIV_S);
		settle();

		// Random phases over several register settings and idle rates.
		set_config(1'b1, PPN_W'(rand64()), 1'b0, PRIV_U);
		run_phase(0, 280);
		set_config(1'b1, 44'd0, 1'b1, PRIV_U);
		run_phase(66, 280);
		set_config(1'b1, PPN_MAX, 1'b1, sv39ptw_pkg::PRIV_M);
		run_phase(21, 260);
		set_config(1'b0, PPN_W'(rand64()), 1'b0, PRIV_S);
		run_phase(66, 150);
		set_config(1'b1, PPN_W'(rand64()), 1'b1, PRIV_S);
		run_phase(21, 280);
		set_config(1'b1, PPN_W'(rand64()), 1'b0, PRIV_H);
		run_phase(0, 280);

		if (!failed) begin
			$display("tb_sv39_tlb_page_table_walker passed");
		end else begin
			$display("tb_sv39_tlb_page_table_walker failed");
		end
		$finish;
	end

	// Watchdog far beyond the slowest correct run.
	initial begin
		#2_000_000;
		$display("tb_sv39_tlb_page_table_walker failed");
		$finish;
	end

endmodule

[sv39_tlb_page_table_walker.f]
rtl/sv39ptw_pkg.sv
rtl/sv39ptw_ram.sv
rtl/sv39_tlb_page_table_walker.sv
sim/tb_sv39_tlb_page_table_walker.sv
